// ===== src/dmc_pkg.sv =====
// shared types and constants for the direct-mapped cache lookup
// no dependencies
package dmc_pkg;

  // cache geometry, LINE_COUNT a power of two
  localparam int unsigned LINE_COUNT  = 128;
  localparam int unsigned OFFSET_BITS = 5;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned INDEX_BITS = $clog2(LINE_COUNT);
  localparam int unsigned TAG_BITS   = ADDR_W - OFFSET_BITS - INDEX_BITS;

  // widths of the result fields
  localparam int unsigned OFFSET_W = 5;
  localparam int unsigned BLOCK_W  = 27;
  localparam int unsigned INDEX_W  = 7;
  localparam int unsigned TAG_W    = 20;
  localparam int unsigned RDB_W    = 6;
  localparam int unsigned CNT_W    = 32;

  localparam logic [ADDR_W-1:0] LINE_BYTES = ADDR_W'(1) << OFFSET_BITS;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic lookup;
  } dmc_cmd_t;

endpackage

// ===== src/dmc_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module dmc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/dmc_ctrl.sv =====
// controller for the cache lookup: accept in idle, then the lookup state, then back to idle
// depends on dmc_pkg
module dmc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  output dmc_pkg::dmc_cmd_t cmd_o
);
  import dmc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy_o        = 1'b0;
    cmd_o.load    = 1'b0;
    cmd_o.lookup  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load = start_i;
      end
      ST_LOOKUP: begin
        busy_o       = 1'b1;
        cmd_o.lookup = 1'b1;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

endmodule

// ===== src/dmc_datapath.sv =====
// datapath: address split, tag ram, valid bits, counters, result registers
// depends on dmc_pkg and dmc_ram
module dmc_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dmc_pkg::dmc_cmd_t             cmd_i,
  input  logic [dmc_pkg::ADDR_W-1:0]    address_i,
  input  logic                          func_i,
  output logic                          valid_o,
  output logic [dmc_pkg::OFFSET_W-1:0]  byte_offset_o,
  output logic [dmc_pkg::BLOCK_W-1:0]   block_number_o,
  output logic [dmc_pkg::INDEX_W-1:0]   line_index_o,
  output logic [dmc_pkg::TAG_W-1:0]     tag_value_o,
  output logic                          miss_o,
  output logic [dmc_pkg::RDB_W-1:0]     mem_read_bytes_o,
  output logic                          mem_write_bytes_o,
  output logic                          replacement_o,
  output logic [dmc_pkg::TAG_W-1:0]     evicted_tag_o,
  output logic [dmc_pkg::CNT_W-1:0]     access_total_o,
  output logic [dmc_pkg::CNT_W-1:0]     miss_total_o
);
  import dmc_pkg::*;

  logic [ADDR_W-1:0]     addr_q;
  logic                  func_q;
  logic [LINE_COUNT-1:0] valid_q, valid_d;
  logic [CNT_W-1:0]      access_q, access_d;
  logic [CNT_W-1:0]      misses_q, misses_d;
  logic                  res_valid_q;

  logic [OFFSET_W-1:0]   offset_q;
  logic [BLOCK_W-1:0]    block_q;
  logic [INDEX_W-1:0]    index_out_q;
  logic [TAG_W-1:0]      tag_out_q;
  logic                  miss_q;
  logic [RDB_W-1:0]      rdb_q;
  logic                  wrb_q;
  logic                  repl_q;
  logic [TAG_W-1:0]      evict_q;

  logic [INDEX_BITS-1:0] idx;
  logic [TAG_BITS-1:0]   tag;
  logic [TAG_BITS-1:0]   stored_tag;
  logic                  hit;
  logic                  fill;
  logic [ADDR_W-1:0]     offset_w, block_w, index_w, tag_w, evict_w;

  // ram read address follows the input so the tag is ready in the lookup cycle
  dmc_ram #(
    .WIDTH(TAG_BITS),
    .DEPTH(LINE_COUNT)
  ) u_tag_ram (
    .clk_i  (clk_i),
    .we_i   (fill),
    .waddr_i(idx),
    .wdata_i(tag),
    .raddr_i(address_i[OFFSET_BITS +: INDEX_BITS]),
    .rdata_o(stored_tag)
  );

  assign idx  = addr_q[OFFSET_BITS +: INDEX_BITS];
  assign tag  = addr_q[ADDR_W-1 -: TAG_BITS];
  assign hit  = valid_q[idx] && (stored_tag == tag);
  assign fill = cmd_i.lookup && !hit && !func_q;

  assign offset_w = addr_q & (LINE_BYTES - ADDR_W'(1));
  assign block_w  = addr_q >> OFFSET_BITS;
  assign index_w  = ADDR_W'(idx);
  assign tag_w    = ADDR_W'(tag);
  assign evict_w  = ADDR_W'(stored_tag);

  always_comb begin
    valid_d  = valid_q;
    access_d = access_q;
    misses_d = misses_q;
    if (cmd_i.lookup) begin
      access_d = access_q + CNT_W'(1);
      if (!hit) misses_d = misses_q + CNT_W'(1);
      if (fill) valid_d[idx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      access_q    <= '0;
      misses_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      access_q    <= access_d;
      misses_q    <= misses_d;
      res_valid_q <= cmd_i.lookup;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      addr_q <= address_i;
      func_q <= func_i;
    end
    if (cmd_i.lookup) begin
      offset_q    <= offset_w[OFFSET_W-1:0];
      block_q     <= block_w[BLOCK_W-1:0];
      index_out_q <= index_w[INDEX_W-1:0];
      tag_out_q   <= tag_w[TAG_W-1:0];
      miss_q      <= !hit;
      rdb_q       <= fill ? LINE_BYTES[RDB_W-1:0] : '0;
      wrb_q       <= func_q;
      // evicted tag reads zero unless a valid line is overwritten
      repl_q      <= fill && valid_q[idx];
      evict_q     <= (fill && valid_q[idx]) ? evict_w[TAG_W-1:0] : '0;
    end
  end

  assign valid_o           = res_valid_q;
  assign byte_offset_o     = offset_q;
  assign block_number_o    = block_q;
  assign line_index_o      = index_out_q;
  assign tag_value_o       = tag_out_q;
  assign miss_o            = miss_q;
  assign mem_read_bytes_o  = rdb_q;
  assign mem_write_bytes_o = wrb_q;
  assign replacement_o     = repl_q;
  assign evicted_tag_o     = evict_q;
  assign access_total_o    = access_q;
  assign miss_total_o      = misses_q;

endmodule

// ===== src/direct_mapped_cache_lookup.sv =====
// top level of the direct-mapped write-through cache tag store
// depends on dmc_pkg, dmc_ctrl and dmc_datapath
//
// usage:
//   a word (address_i, func_i) is taken at a rising edge where start_i is
//   high and busy_o is low. func_i is 0 for a read, 1 for a write.
//   the result word appears on the result ports for exactly one cycle with
//   valid_o high; the receiver cannot stall, so it must take it then.
// sequence:
//   the word is registered and the tag ram is read on the accepting edge;
//   the lookup and update happen in the lookup state, then valid_o is set.
//   busy_o is high only in the lookup state, so a new word can be taken
//   while valid_o is high for the previous one.
// reset:
//   rst_ni clears all valid bits, both running counts and the controller
//   at once; no clearing pass is needed and a word can be taken right after.
//   access_total_o and miss_total_o hold their values between results.
module direct_mapped_cache_lookup (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [dmc_pkg::ADDR_W-1:0]    address_i,
  input  logic                          func_i,
  output logic                          valid_o,
  output logic [dmc_pkg::OFFSET_W-1:0]  byte_offset_o,
  output logic [dmc_pkg::BLOCK_W-1:0]   block_number_o,
  output logic [dmc_pkg::INDEX_W-1:0]   line_index_o,
  output logic [dmc_pkg::TAG_W-1:0]     tag_value_o,
  output logic                          miss_o,
  output logic [dmc_pkg::RDB_W-1:0]     mem_read_bytes_o,
  output logic                          mem_write_bytes_o,
  output logic                          replacement_o,
  output logic [dmc_pkg::TAG_W-1:0]     evicted_tag_o,
  output logic [dmc_pkg::CNT_W-1:0]     access_total_o,
  output logic [dmc_pkg::CNT_W-1:0]     miss_total_o
);
  import dmc_pkg::*;

  dmc_cmd_t cmd;

  dmc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .cmd_o  (cmd)
  );

  dmc_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .address_i        (address_i),
    .func_i           (func_i),
    .valid_o          (valid_o),
    .byte_offset_o    (byte_offset_o),
    .block_number_o   (block_number_o),
    .line_index_o     (line_index_o),
    .tag_value_o      (tag_value_o),
    .miss_o           (miss_o),
    .mem_read_bytes_o (mem_read_bytes_o),
    .mem_write_bytes_o(mem_write_bytes_o),
    .replacement_o    (replacement_o),
    .evicted_tag_o    (evicted_tag_o),
    .access_total_o   (access_total_o),
    .miss_total_o     (miss_total_o)
  );

  // an accepted word always moves to the lookup cycle
  a_accept_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted word did not enter lookup");

  // every lookup cycle yields exactly one result strobe
  a_lookup_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> (valid_o && !busy_o))
    else $error("lookup did not produce a result");

  // each result bumps the access count by one
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && $past(rst_ni, 2)) |->
      (access_total_o == $past(access_total_o, 2) + CNT_W'(1)))
    else $error("access count out of step with results");

  // a replacement only comes from a read miss
  a_repl_read_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && replacement_o) |-> (miss_o && !mem_write_bytes_o))
    else $error("replacement without a read miss");

endmodule
